// ----- sv/wrp_pkg.sv -----
// Shared types and constants for the WAV RIFF stream parser.
// Used by wrp_parser, wrp_out_queue and wav_riff_stream_parser; no dependencies.
`default_nettype none

package wrp_pkg;

   // Chunk and header tags as they appear after four little-endian bytes.
   localparam logic [31:0] TAG_RIFF     = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE     = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT      = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
   localparam logic [15:0] SIGN_FLIP    = 16'h8000;
   localparam logic [31:0] DEFAULT_RATE = 32'd22050;
   localparam logic [30:0] FRAME_MAX    = 31'h7FFF_FFFF;

   // Entries in the result queue; its two-bit count is sized for three.
   localparam int unsigned QUEUE_DEPTH  = 3;

   typedef enum logic [1:0] {
      KIND_FORMAT   = 2'd0,
      KIND_SAMPLE   = 2'd1,
      KIND_FINISHED = 2'd2,
      KIND_REJECTED = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_HEADER    = 3'd1,
      ERR_NOT_PCM   = 3'd2,
      ERR_CHANNELS  = 3'd3,
      ERR_BITS      = 3'd4,
      ERR_TRUNCATED = 3'd5
   } err_code_type;

   typedef struct packed {
      kind_type     kind;
      logic [15:0]  sample_value;
      logic         channel_index;
      logic [31:0]  sample_rate;
      logic [1:0]   channel_count;
      logic [4:0]   bit_depth;
      logic [30:0]  frame_count;
      err_code_type error_code;
      logic         last_result;
   } result_type;

   // Results produced by one accepted byte; second_valid implies first_valid.
   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

// ----- sv/wav_riff_stream_parser.sv -----
// Top level of the WAV RIFF stream parser: byte input stream, result stream.
// Depends on wrp_pkg, wrp_parser and wrp_out_queue.
`default_nettype none

// The block takes a WAV file one byte per word on the req_ channel, with
// req_tlast set on the final byte of the file, and returns result words on
// the rsp_ channel: a format report at each data chunk, one word per sample,
// and a closing word (finished ok or rejected) that carries rsp_tlast.
// The result kind travels in rsp_tuser.
//
// Throughput is one byte per clock while req_tready is high. Each byte is
// parsed in the cycle it is accepted; its results go to a three-word output
// queue, and if that is empty the first is visible on rsp_tvalid in the
// cycle after acceptance. A byte yields at most two results (only the final
// byte of a file can); req_tready stays high while the queue holds at most
// one word, so a stalled receiver does not stop input until two words wait.
// The queue drains at one word per cycle while rsp_tready is high.
//
// Reset is synchronous and puts the parser back at the start of a file with
// the default format of 22050 Hz, 8 bits, mono, and empties the queue.
// After the final byte of a file the parser returns to the same state by
// itself, ready for the next file on the following byte.

module wav_riff_stream_parser
   import wrp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_file
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] sample_value, [16] channel_index, [48:17] sample_rate,
   // [50:49] channel_count, [55:51] bit_depth, [86:56] frame_count,
   // [89:87] error_code, [95:90] zero
   output logic [95:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // last_result
);

   logic       accept;
   logic       room;
   push_type   push;
   result_type head;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   wrp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_tdata),
      .end_of_file (req_tlast),
      .push        (push)
   );

   wrp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head       (head),
      .head_ready (rsp_tready)
   );

   assign rsp_tdata = {6'd0, head.error_code, head.frame_count, head.bit_depth,
                       head.channel_count, head.sample_rate, head.channel_index,
                       head.sample_value};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_result;

endmodule

`default_nettype wire

// ----- sv/wrp_parser.sv -----
// Byte-wise RIFF/WAVE parser state machine: one accepted byte per cycle,
// up to two result words per byte. Depends on wrp_pkg.
`default_nettype none

module wrp_parser
   import wrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       end_of_file,
   output push_type        push
);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_CHUNK  = 3'd1,
      PH_FMT    = 3'd2,
      PH_SKIP   = 3'd3,
      PH_DATA8  = 3'd4,
      PH_DATA16 = 3'd5,
      PH_DRAIN  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      CK_OTHER = 2'd0,
      CK_FMT   = 2'd1,
      CK_DATA  = 2'd2
   } chunk_kind_type;

   phase_type      phase_ff, phase_in;
   logic [3:0]     pos_ff, pos_in;
   logic [31:0]    shift_ff, shift_in;
   logic [31:0]    chunk_rem_ff, chunk_rem_in;
   logic [31:0]    words_rem_ff, words_rem_in;
   logic [1:0]     channels_ff, channels_in;
   logic [4:0]     bits_ff, bits_in;
   logic [31:0]    rate_ff, rate_in;
   logic [7:0]     low_hold_ff, low_hold_in;
   logic           toggle_ff, toggle_in;
   chunk_kind_type kind_ff, kind_in;
   logic           seen_ff, seen_in;

   err_code_type   err;
   logic           prim_valid;
   result_type     prim;
   result_type     tail;
   logic           tail_valid;
   logic           stereo;
   logic           wide;
   logic [31:0]    len;
   logic [31:0]    frames;
   logic [31:0]    words_dec;

   assign stereo    = (channels_ff == 2'd2);
   assign wide      = (bits_ff == 5'd16);
   assign len       = shift_in;
   assign words_dec = words_rem_ff - 32'd1;

   // Channels are 1 or 2 and the depth 8 or 16, so the division is a shift.
   always_comb begin
      unique case ({wide, stereo})
         2'b00:   frames = len;
         2'b01:   frames = {1'b0, len[31:1]};
         2'b10:   frames = {1'b0, len[31:1]};
         default: frames = {2'b0, len[31:2]};
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      shift_in     = shift_ff;
      chunk_rem_in = chunk_rem_ff;
      words_rem_in = words_rem_ff;
      channels_in  = channels_ff;
      bits_in      = bits_ff;
      rate_in      = rate_ff;
      low_hold_in  = low_hold_ff;
      toggle_in    = toggle_ff;
      kind_in      = kind_ff;
      seen_in      = seen_ff;
      err          = ERR_NONE;
      prim_valid   = 1'b0;
      prim         = '0;
      tail         = '0;
      tail_valid   = 1'b0;

      if (phase_ff != PH_DATA8 && phase_ff != PH_DATA16) begin
         shift_in = {data_byte, shift_ff[31:8]};
      end

      unique case (phase_ff)
         PH_HEADER: begin
            if (pos_ff == 4'd3 && shift_in != TAG_RIFF) begin
               err = ERR_HEADER;
            end else if (pos_ff == 4'd11 && shift_in != TAG_WAVE) begin
               err = ERR_HEADER;
            end else if (pos_ff == 4'd11) begin
               phase_in = PH_CHUNK;
               pos_in   = '0;
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end
         PH_CHUNK: begin
            if (pos_ff == 4'd3) begin
               if (shift_in == TAG_FMT) begin
                  kind_in = CK_FMT;
               end else if (shift_in == TAG_DATA) begin
                  kind_in = CK_DATA;
               end else begin
                  kind_in = CK_OTHER;
               end
               pos_in = pos_ff + 4'd1;
            end else if (pos_ff == 4'd7) begin
               pos_in       = '0;
               chunk_rem_in = len;
               unique case (kind_ff)
                  CK_FMT: begin
                     phase_in = PH_FMT;
                  end
                  CK_DATA: begin
                     seen_in            = 1'b1;
                     toggle_in          = 1'b0;
                     prim_valid         = 1'b1;
                     prim.kind          = KIND_FORMAT;
                     prim.sample_rate   = rate_ff;
                     prim.channel_count = channels_ff;
                     prim.bit_depth     = bits_ff;
                     prim.frame_count   = frames[31] ? FRAME_MAX : frames[30:0];
                     if (wide) begin
                        // frames * channels, with channels 1 or 2
                        words_rem_in = stereo ? {1'b0, len[31:2], 1'b0}
                                              : {1'b0, len[31:1]};
                        phase_in     = PH_DATA16;
                     end else begin
                        words_rem_in = len;
                        phase_in     = PH_DATA8;
                     end
                     if (words_rem_in == '0) begin
                        phase_in = PH_CHUNK;
                     end
                  end
                  default: begin
                     phase_in = (len != '0) ? PH_SKIP : PH_CHUNK;
                  end
               endcase
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end
         PH_FMT: begin
            pos_in = pos_ff + 4'd1;
            if (pos_ff == 4'd1 && shift_in[31:16] != 16'd1) begin
               err = ERR_NOT_PCM;
            end else if (pos_ff == 4'd3) begin
               if (shift_in[31:16] != 16'd1 && shift_in[31:16] != 16'd2) begin
                  err = ERR_CHANNELS;
               end else begin
                  channels_in = shift_in[17:16];
               end
            end else if (pos_ff == 4'd7) begin
               rate_in = shift_in;
            end else if (pos_ff == 4'd15) begin
               if (shift_in[31:16] != 16'd8 && shift_in[31:16] != 16'd16) begin
                  err = ERR_BITS;
               end else begin
                  bits_in      = shift_in[20:16];
                  pos_in       = '0;
                  chunk_rem_in = (chunk_rem_ff > 32'd16) ? chunk_rem_ff - 32'd16 : '0;
                  phase_in     = (chunk_rem_in != '0) ? PH_SKIP : PH_CHUNK;
               end
            end
         end
         PH_SKIP: begin
            chunk_rem_in = chunk_rem_ff - 32'd1;
            if (chunk_rem_in == '0) begin
               phase_in = PH_CHUNK;
               pos_in   = '0;
            end
         end
         PH_DATA8, PH_DATA16: begin
            if (phase_ff == PH_DATA16 && pos_ff == 4'd0) begin
               low_hold_in = data_byte;
               pos_in      = 4'd1;
            end else begin
               prim_valid         = 1'b1;
               prim.kind          = KIND_SAMPLE;
               prim.channel_index = toggle_ff;
               if (phase_ff == PH_DATA16) begin
                  pos_in            = '0;
                  prim.sample_value = {data_byte, low_hold_ff} ^ SIGN_FLIP;
               end else begin
                  prim.sample_value = {8'd0, data_byte};
               end
               words_rem_in = words_dec;
               if (stereo) begin
                  toggle_in = ~toggle_ff;
               end
               if (words_dec == '0) begin
                  phase_in = PH_CHUNK;
                  pos_in   = '0;
               end
            end
         end
         default: begin
         end
      endcase

      // An error before any data chunk rejects the file; after one it only
      // stops parsing.
      if (err != ERR_NONE) begin
         if (!seen_ff) begin
            prim_valid       = 1'b1;
            prim             = '0;
            prim.kind        = KIND_REJECTED;
            prim.error_code  = err;
            prim.last_result = 1'b1;
         end
         phase_in = PH_DRAIN;
      end

      if (end_of_file) begin
         tail.last_result = 1'b1;
         if (seen_in) begin
            tail_valid = 1'b1;
            tail.kind  = KIND_FINISHED;
         end else if (err == ERR_NONE && phase_in != PH_DRAIN) begin
            tail_valid      = 1'b1;
            tail.kind       = KIND_REJECTED;
            tail.error_code = ERR_TRUNCATED;
         end
         phase_in     = PH_HEADER;
         pos_in       = '0;
         shift_in     = '0;
         chunk_rem_in = '0;
         words_rem_in = '0;
         channels_in  = 2'd1;
         bits_in      = 5'd8;
         rate_in      = DEFAULT_RATE;
         toggle_in    = 1'b0;
         kind_in      = CK_OTHER;
         seen_in      = 1'b0;
      end
   end

   always_comb begin
      push.first_valid  = accept && (prim_valid || tail_valid);
      push.second_valid = accept && prim_valid && tail_valid;
      push.first        = prim_valid ? prim : tail;
      push.second       = tail;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         shift_ff     <= '0;
         chunk_rem_ff <= '0;
         words_rem_ff <= '0;
         channels_ff  <= 2'd1;
         bits_ff      <= 5'd8;
         rate_ff      <= DEFAULT_RATE;
         toggle_ff    <= 1'b0;
         kind_ff      <= CK_OTHER;
         seen_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         shift_ff     <= shift_in;
         chunk_rem_ff <= chunk_rem_in;
         words_rem_ff <= words_rem_in;
         channels_ff  <= channels_in;
         bits_ff      <= bits_in;
         rate_ff      <= rate_in;
         toggle_ff    <= toggle_in;
         kind_ff      <= kind_in;
         seen_ff      <= seen_in;
      end
   end

   // The low byte of a 16-bit sample is always written before it is used.
   always_ff @(posedge clock) begin
      if (accept) begin
         low_hold_ff <= low_hold_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/wrp_out_queue.sv -----
// Three-word result queue that takes up to two words per cycle and hands
// one word per cycle to the result channel on head_ready. Depends on wrp_pkg.
`default_nettype none

module wrp_out_queue
   import wrp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  push_type  push,
   output logic      room,
   output logic      head_valid,
   output result_type head,
   input  wire logic head_ready
);

   result_type q_ff [QUEUE_DEPTH];
   result_type q_in [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic [1:0] base;
   logic       pop;

   assign pop        = (count_ff != 2'd0) && head_ready;
   assign base       = count_ff - {1'b0, pop};
   assign room       = !count_ff[1];
   assign head_valid = (count_ff != 2'd0);
   assign head       = q_ff[0];
   assign count_in   = base + {1'b0, push.first_valid} + {1'b0, push.second_valid};

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (push.first_valid && base == 2'(i)) begin
            q_in[i] = push.first;
         end
         if (push.second_valid && base + 2'd1 == 2'(i)) begin
            q_in[i] = push.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> room)
      else $error("result pushed without two free entries");

   a_second_after_first: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid)
      else $error("second result pushed without a first");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push.first_valid) |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue count did not drop after a pop");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3 || !room)
      else $error("queue reports room while full");

endmodule

`default_nettype wire
